>>> src/imufp_pkg.sv
// Package for the IMU frame parser: constants, state types and field layout.
`timescale 1ns / 1ps

package imufp_pkg;

  // Frame sync bytes
  localparam logic [7:0] SYNC_FIRST  = 8'h88;
  localparam logic [7:0] SYNC_SECOND = 8'hAF;

  // Default payload store depth
  localparam int unsigned BUFFER_DEPTH_DEF = 64;

  // Field layout of the payload
  localparam int unsigned NUM_FIELDS      = 13;
  localparam logic [3:0]  PRESSURE_FIELD  = 4'd12;
  localparam logic [4:0]  PRESS_FIRST_BYTE = 5'd24;
  localparam logic [4:0]  LAST_BYTE       = 5'd27;

  // Framing state, one-hot
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_SYNC2 = 4'b0010,
    PH_LEN   = 4'b0100,
    PH_DATA  = 4'b1000
  } parse_phase_e;

  // Decode sequencer state, one-hot
  typedef enum logic [3:0] {
    SQ_IDLE  = 4'b0001,
    SQ_FETCH = 4'b0010,
    SQ_ACCUM = 4'b0100,
    SQ_PUSH  = 4'b1000
  } seq_state_e;

endpackage

>>> src/imufp_ifs.sv
// Handshake channels of the IMU frame parser: received bytes and decoded fields.
`timescale 1ns / 1ps

interface imufp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imufp_field_if;
  logic               valid;
  logic               ready;
  logic [3:0]         field_index;
  logic signed [31:0] field_value;
  logic               last;

  modport source (output valid, output field_index, output field_value, output last,
                  input ready);
  modport sink   (input valid, input field_index, input field_value, input last,
                  output ready);
endinterface

>>> src/imufp_payload_store.sv
// Payload byte store: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps

module imufp_payload_store
  import imufp_pkg::*;
#(
  parameter int unsigned BufferDepth = BUFFER_DEPTH_DEF,
  localparam int unsigned AddrW      = $clog2(BufferDepth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0]             mem [BufferDepth];
  logic [BufferDepth-1:0] vld_q;
  logic [7:0]             rd_data_q;

  // Valid bits: an entry never written since reset reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // Storage array and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= vld_q[rd_addr_i] ? mem[rd_addr_i] : 8'h00;
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/imu_frame_parser.sv
// Top level of the IMU frame parser: framing FSM, field decode sequencer, output register.
`timescale 1ns / 1ps

// Usage:
//  rx_i takes one received byte per item. The parser hunts for 0x88 then 0xAF,
//  takes a length byte, stores that many payload bytes (positions past the store
//  depth are counted and dropped), and the next byte closes the frame.
//  field_o then delivers 13 items: accel, gyro, mag x/y/z, roll, pitch, yaw as
//  sign-extended big-endian 16-bit values, and pressure as a little-endian 32-bit
//  value, with last set on the pressure item.
//  rx_i takes a byte in any cycle in which the decode sequencer is idle. After the
//  closing byte the decode sequencer walks payload bytes 0..27 through the store's
//  single registered read port, with a fetch and an accumulate step per byte plus a
//  push step per field to load the output register, during which rx_i is not ready.
//  Stall: while field_o is stalled the sequencer holds; the output register lets
//  rx_i resume as soon as the last field is loaded, even if it is not yet taken.
//  Reset: framing returns to hunting 0x88, the store reads as all zero, and any
//  pending field is dropped.
module imu_frame_parser
  import imufp_pkg::*;
#(
  parameter int unsigned BufferDepth = BUFFER_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  imufp_rx_if.sink           rx_i,
  imufp_field_if.source      field_o
);

  localparam int unsigned AddrW = $clog2(BufferDepth);

  parse_phase_e       phase_q, phase_d;
  seq_state_e         seq_q, seq_d;
  logic [7:0]         cnt_q, cnt_d;
  logic [7:0]         len_q, len_d;
  logic [4:0]         rd_idx_q, rd_idx_d;
  logic [3:0]         fld_q, fld_d;
  logic [31:0]        acc_q, acc_d;
  logic               out_vld_q, out_vld_d;
  logic [3:0]         out_idx_q, out_idx_d;
  logic signed [31:0] out_val_q, out_val_d;
  logic               out_last_q, out_last_d;

  logic               in_acc;
  logic               wr_en;
  logic [7:0]         rd_data;
  logic               fld_done;
  logic               out_free;

  assign rx_i.ready = (seq_q == SQ_IDLE);
  assign in_acc     = rx_i.valid && rx_i.ready;
  assign out_free   = !out_vld_q || field_o.ready;

  // Field ends on the low byte of a 16-bit field or on the last pressure byte
  assign fld_done = (rd_idx_q == LAST_BYTE) || ((rd_idx_q < PRESS_FIRST_BYTE) && rd_idx_q[0]);

  imufp_payload_store #(
    .BufferDepth (BufferDepth)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (cnt_q[AddrW-1:0]),
    .wr_data_i (rx_i.rx_byte),
    .rd_addr_i (AddrW'(rd_idx_q)),
    .rd_data_o (rd_data)
  );

  // Framing and decode sequencing
  always_comb begin
    phase_d    = phase_q;
    seq_d      = seq_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    rd_idx_d   = rd_idx_q;
    fld_d      = fld_q;
    acc_d      = acc_q;
    wr_en      = 1'b0;
    out_vld_d  = out_vld_q && !field_o.ready;
    out_idx_d  = out_idx_q;
    out_val_d  = out_val_q;
    out_last_d = out_last_q;

    unique case (seq_q)
      SQ_IDLE: begin
        if (in_acc) begin
          unique case (phase_q)
            PH_IDLE: begin
              if (rx_i.rx_byte == SYNC_FIRST) phase_d = PH_SYNC2;
            end
            PH_SYNC2: begin
              if (rx_i.rx_byte == SYNC_SECOND) phase_d = PH_LEN;
            end
            PH_LEN: begin
              len_d   = rx_i.rx_byte;
              cnt_d   = 8'd0;
              phase_d = PH_DATA;
            end
            PH_DATA: begin
              if (cnt_q != len_q) begin
                wr_en = ({1'b0, cnt_q} < 9'(BufferDepth));
                cnt_d = cnt_q + 8'd1;
              end else begin
                // closing byte: start decoding
                phase_d  = PH_IDLE;
                seq_d    = SQ_FETCH;
                rd_idx_d = 5'd0;
                fld_d    = 4'd0;
              end
            end
            default: phase_d = PH_IDLE;
          endcase
        end
      end
      SQ_FETCH: begin
        // read address is presented this cycle, data is registered
        seq_d = SQ_ACCUM;
      end
      SQ_ACCUM: begin
        if (fld_q == PRESSURE_FIELD) begin
          acc_d = {rd_data, acc_q[31:8]};
        end else begin
          acc_d = {acc_q[23:0], rd_data};
        end
        rd_idx_d = rd_idx_q + 5'd1;
        seq_d    = fld_done ? SQ_PUSH : SQ_FETCH;
      end
      SQ_PUSH: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_idx_d  = fld_q;
          out_last_d = (fld_q == PRESSURE_FIELD);
          if (fld_q == PRESSURE_FIELD) begin
            out_val_d = acc_q;
            seq_d     = SQ_IDLE;
          end else begin
            out_val_d = {{16{acc_q[15]}}, acc_q[15:0]};
            seq_d     = SQ_FETCH;
          end
          fld_d = fld_q + 4'd1;
        end
      end
      default: seq_d = SQ_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      seq_q     <= SQ_IDLE;
      cnt_q     <= 8'd0;
      len_q     <= 8'd0;
      rd_idx_q  <= 5'd0;
      fld_q     <= 4'd0;
      out_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      seq_q     <= seq_d;
      cnt_q     <= cnt_d;
      len_q     <= len_d;
      rd_idx_q  <= rd_idx_d;
      fld_q     <= fld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign field_o.valid       = out_vld_q;
  assign field_o.field_index = out_idx_q;
  assign field_o.field_value = out_val_q;
  assign field_o.last        = out_last_q;

endmodule

>>> verif/imu_frame_parser_tb.sv
// Self-checking testbench for the IMU frame parser: byte stimulus, field prediction, scoreboard.
`timescale 1ns / 1ps

module imu_frame_parser_tb
  import imufp_pkg::*;
;

  localparam int unsigned STORE_DEPTH    = BUFFER_DEPTH_DEF;
  localparam int unsigned RAND_ITEMS     = 100;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 150;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DIR_ROWS       = 24;

  // One decoded field as the block should deliver it
  typedef struct {
    logic [3:0]         index;
    logic signed [31:0] value;
    logic               last;
  } field_item_t;

  // Directed row: one byte, plus typed fields when it closes a frame
  typedef struct {
    logic [7:0]         rx_byte;
    logic               pin;
    logic signed [31:0] acc_x;
    logic signed [31:0] rest;
    logic signed [31:0] press;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  imufp_rx_if    rx_ch ();
  imufp_field_if fld_ch ();

  imu_frame_parser #(
    .BufferDepth(STORE_DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_ch),
    .field_o(fld_ch)
  );

  always #2 clk_i = ~clk_i;

  // Framer copy used for prediction
  parse_phase_e fr_phase;
  logic [7:0]   fr_count;
  logic [7:0]   fr_len;
  logic [7:0]   fr_store [STORE_DEPTH];

  field_item_t field_exp_q [$];

  int unsigned fails        = 0;
  int unsigned bytes_sent   = 0;
  int unsigned frame_bytes  = 0;
  int unsigned frames_closed = 0;
  int unsigned fields_seen  = 0;
  int unsigned quiet_cycles = 0;
  bit          hold_req     = 1'b0;

  // Directed bytes: noise, wrong second sync, zero length, short frames, 16-bit extremes
  stim_row_t dir_rows [DIR_ROWS] = '{
    // zero-length frame right after reset: all fields read the cleared store
    '{8'h88, 1'b0, 0, 0, 0}, '{8'hAF, 1'b0, 0, 0, 0}, '{8'h00, 1'b0, 0, 0, 0},
    '{8'h00, 1'b1, 0, 0, 0},
    // idle noise, then a bad second sync where a repeated 0x88 does not restart
    '{8'h00, 1'b0, 0, 0, 0}, '{8'hAF, 1'b0, 0, 0, 0}, '{8'h88, 1'b0, 0, 0, 0},
    '{8'h55, 1'b0, 0, 0, 0}, '{8'h88, 1'b0, 0, 0, 0}, '{8'hAF, 1'b0, 0, 0, 0},
    '{8'h00, 1'b0, 0, 0, 0}, '{8'h7E, 1'b1, 0, 0, 0},
    // short frame, most negative accel x, stale zeros elsewhere
    '{8'h88, 1'b0, 0, 0, 0}, '{8'hAF, 1'b0, 0, 0, 0}, '{8'h02, 1'b0, 0, 0, 0},
    '{8'h80, 1'b0, 0, 0, 0}, '{8'h00, 1'b0, 0, 0, 0}, '{8'hFF, 1'b1, -32768, 0, 0},
    // short frame, most positive accel x
    '{8'h88, 1'b0, 0, 0, 0}, '{8'hAF, 1'b0, 0, 0, 0}, '{8'h02, 1'b0, 0, 0, 0},
    '{8'h7F, 1'b0, 0, 0, 0}, '{8'hFF, 1'b0, 0, 0, 0}, '{8'h00, 1'b1, 32767, 0, 0}
  };

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Payload byte with the sign and range extremes over-weighted
  function automatic logic [7:0] rand_data_byte();
    logic [7:0] corner [4];
    corner = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    if ($urandom_range(0, 3) == 0) return corner[$urandom_range(0, 3)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Advance the framer by one byte; returns 1 when the byte closes a frame
  function automatic bit advance_framer(input logic [7:0] b);
    bit closed;
    closed = 1'b0;
    case (fr_phase)
      PH_IDLE: begin
        if (b == SYNC_FIRST) fr_phase = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (b == SYNC_SECOND) fr_phase = PH_LEN;
      end
      PH_LEN: begin
        fr_len   = b;
        fr_count = 8'd0;
        fr_phase = PH_DATA;
      end
      default: begin
        if (fr_count != fr_len) begin
          // positions past the store are counted only
          if (int'(fr_count) < STORE_DEPTH) fr_store[fr_count] = b;
          fr_count = fr_count + 8'd1;
        end else begin
          fr_phase = PH_IDLE;
          closed   = 1'b1;
        end
      end
    endcase
    return closed;
  endfunction

  // Decode the store into the 13 field items of a closed frame
  function automatic void push_decoded_fields();
    field_item_t f;
    int unsigned p;
    p = PRESS_FIRST_BYTE;
    for (int k = 0; k < NUM_FIELDS; k++) begin
      f.index = 4'(k);
      f.last  = (4'(k) == PRESSURE_FIELD);
      if (f.last)
        f.value = {fr_store[p + 3], fr_store[p + 2], fr_store[p + 1], fr_store[p]};
      else
        f.value = {{16{fr_store[2 * k][7]}}, fr_store[2 * k], fr_store[2 * k + 1]};
      field_exp_q.push_back(f);
    end
    frames_closed++;
  endfunction

  // Offer one byte after a random gap and wait for it to be taken
  task automatic send_byte(input logic [7:0] b, input bit calm, input bit typed,
                           output bit closed);
    int unsigned gap;
    gap = pick_gap(calm);
    @(negedge clk_i);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk_i); while (!rx_ch.ready);
    bytes_sent++;
    closed = advance_framer(b);
    if (closed && !typed) push_decoded_fields();
  endtask

  // Well-formed frame with random payload and closing byte
  task automatic send_frame(input logic [7:0] len, input bit calm);
    bit closed;
    send_byte(SYNC_FIRST, calm, 1'b0, closed);
    send_byte(SYNC_SECOND, calm, 1'b0, closed);
    send_byte(len, calm, 1'b0, closed);
    for (int i = 0; i < int'(len); i++) send_byte(rand_data_byte(), calm, 1'b0, closed);
    send_byte(rand_data_byte(), calm, 1'b0, closed);
    frame_bytes += int'(len) + 4;
  endtask

  // Wait for every pending field, then let the sequencer settle
  task automatic drain_fields();
    while (field_exp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Reset, once
  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Byte source
  initial begin : byte_source
    bit          closed;
    bit          calm;
    int unsigned kind;
    int unsigned n;
    field_item_t f;

    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    fr_phase      = PH_IDLE;
    fr_count      = 8'd0;
    fr_len        = 8'd0;
    for (int i = 0; i < STORE_DEPTH; i++) fr_store[i] = 8'h00;
    wait (rst_ni);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(dir_rows[i].rx_byte, 1'b0, dir_rows[i].pin, closed);
      if (closed && dir_rows[i].pin) begin
        for (int k = 0; k < NUM_FIELDS; k++) begin
          f.index = 4'(k);
          f.last  = (4'(k) == PRESSURE_FIELD);
          if (f.last) f.value = dir_rows[i].press;
          else if (k == 0) f.value = dir_rows[i].acc_x;
          else f.value = dir_rows[i].rest;
          field_exp_q.push_back(f);
        end
        frames_closed++;
      end
    end

    // sender pause until the block has delivered everything
    @(negedge clk_i);
    rx_ch.valid <= 1'b0;
    drain_fields();

    // frame running two bytes past the store under a long receiver hold,
    // sender keeps offering
    hold_req = 1'b1;
    send_frame(8'(STORE_DEPTH + 2), 1'b1);

    // random frames, mostly well formed
    while (bytes_sent < RAND_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        send_frame(8'd28, calm);
      end else if (kind < 70) begin
        send_frame(8'($urandom_range(0, 27)), calm);
      end else if (kind < 80) begin
        // crosses the store depth at times
        send_frame(8'($urandom_range(29, 80)), calm);
      end else if (kind < 90) begin
        // broken sync: first byte then junk
        send_byte(SYNC_FIRST, calm, 1'b0, closed);
        n = $urandom_range(1, 3);
        repeat (n) send_byte(8'($urandom_range(0, 255)), calm, 1'b0, closed);
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom_range(0, 255)), calm, 1'b0, closed);
      end
    end

    @(negedge clk_i);
    rx_ch.valid <= 1'b0;
    drain_fields();

    $display("Covered %0d bytes (%0d in framed packets) and %0d closed frames; %0d fields checked.",
             bytes_sent, frame_bytes, frames_closed, fields_seen);
    $display("Included sync errors, zero/short/overlong frames and a long output hold.");
    if (fails == 0)
      $display("imu_frame_parser regression: pass");
    else
      $display("imu_frame_parser regression: fail");
    $finish;
  end

  // Field sink: random stalls, calm stretches, one long hold on request
  initial begin : field_sink
    int unsigned n;
    int unsigned calm_left;
    bit          calm;

    fld_ch.ready = 1'b0;
    calm         = 1'b0;
    calm_left    = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(20, 80);
      end else begin
        calm_left--;
      end
      if (hold_req) begin
        fld_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        n = pick_gap(calm);
        if (n == 0) begin
          fld_ch.ready <= 1'b1;
        end else begin
          fld_ch.ready <= 1'b0;
          repeat (n - 1) @(negedge clk_i);
        end
      end
    end
  end

  // Compare each taken field item with the oldest expectation
  always @(posedge clk_i) begin : field_check
    field_item_t want;
    if (rst_ni && fld_ch.valid && fld_ch.ready) begin
      fields_seen++;
      if (field_exp_q.size() == 0) begin
        $error("unexpected field item: index %0d value %0d last %0b",
               fld_ch.field_index, fld_ch.field_value, fld_ch.last);
        fails++;
      end else begin
        want = field_exp_q.pop_front();
        if (fld_ch.field_index !== want.index) begin
          $error("field_index: expected %0d, actual %0d", want.index, fld_ch.field_index);
          fails++;
        end
        if (fld_ch.field_value !== want.value) begin
          $error("field_value: expected %0d, actual %0d", want.value, fld_ch.field_value);
          fails++;
        end
        if (fld_ch.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, fld_ch.last);
          fails++;
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (rx_ch.valid && rx_ch.ready) || (fld_ch.valid && fld_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("imu_frame_parser regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
